// ===== hdl/fatt_pkg.sv =====
// Shared constants for the fully associative translation table.
`timescale 1ns / 1ps

package fatt_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int MODE_W    = 3;
  localparam int ADDR_W    = 64;
  localparam int FLAG_W    = 12;
  localparam int ENTRY_W   = 2 * ADDR_W;

  localparam logic [MODE_W-1:0] OP_MAP         = 3'd0;
  localparam logic [MODE_W-1:0] OP_UNMAP       = 3'd1;
  localparam logic [MODE_W-1:0] OP_LOOKUP      = 3'd2;
  localparam logic [MODE_W-1:0] OP_FLUSH_ALL   = 3'd3;
  localparam logic [MODE_W-1:0] OP_FLUSH_RANGE = 3'd4;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  typedef struct packed {
    logic              st;
    logic [ADDR_W-1:0] phys;
    logic [FLAG_W-1:0] flags;
  } fatt_res_t;

endpackage

// ===== hdl/fatt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module fatt_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/fully_associative_translation_table_unit.sv =====
// Top level of the fully associative translation table.
//
// Input channel (in_*): one word per operation, chosen by in_mode (map, unmap,
// lookup, flush all, flush range). Result channel (out_*): exactly one word per
// input word, in order: status, and for a lookup hit the physical part and flags.
// Both channels use valid/stall; a word moves when valid is high and stall low.
// Slot tags and words live in one RAM of SLOTS entries, read one slot a cycle.
// Map, unmap and lookup scan slots from 0 upward and stop at the first match:
// a free slot for map, a matching tag for unmap and lookup. Flush range scans
// all slots; flush all sweeps zeros through the RAM. An unused mode answers
// with a fail status and no scan.
// One operation is in flight at a time; the scan through the single read port
// sets the rate. A new word is accepted once the previous result sits in the
// output register, even if the receiver is still stalling it.
// After reset a clearing pass writes zero to every slot, with in_stall held
// high. A stalled result holds in the output register and the block waits
// with it before loading the next one.
`timescale 1ns / 1ps

module fully_associative_translation_table_unit #(
  parameter int SLOTS = fatt_pkg::SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [fatt_pkg::MODE_W-1:0]  in_mode,
  input  logic [fatt_pkg::ADDR_W-1:0]  in_virt_addr,
  input  logic [fatt_pkg::ADDR_W-1:0]  in_range_end,
  input  logic [fatt_pkg::ADDR_W-1:0]  in_phys_addr,
  input  logic [fatt_pkg::FLAG_W-1:0]  in_page_flags,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_status,
  output logic [fatt_pkg::ADDR_W-1:0]  out_found_phys,
  output logic [fatt_pkg::FLAG_W-1:0]  out_found_flags
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int DW = fatt_pkg::ADDR_W;
  localparam int FW = fatt_pkg::FLAG_W;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic [AW-1:0] chk_idx_r, chk_idx_nxt;
  logic          flush_r, flush_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [fatt_pkg::MODE_W-1:0] mode_r;
  logic [DW-1:0] va_r, vend_r, pa_r;
  logic [FW-1:0] fl_r;

  fatt_pkg::fatt_res_t res_r, res_nxt;
  fatt_pkg::fatt_res_t out_r;

  logic                         ram_we, ram_re;
  logic [AW-1:0]                ram_waddr, ram_raddr;
  logic [fatt_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic [DW-1:0] slot_tag, slot_word;
  logic          tag_hit, slot_free, in_rng, in_acc, is_last;

  fatt_ram #(
    .WIDTH (fatt_pkg::ENTRY_W),
    .DEPTH (SLOTS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;

  assign slot_tag  = ram_rdata[fatt_pkg::ENTRY_W-1:DW];
  assign slot_word = ram_rdata[DW-1:0];
  assign tag_hit   = (slot_tag == va_r);
  assign slot_free = (slot_word == '0);
  assign in_rng    = (slot_tag >= va_r) && (slot_tag < vend_r);
  assign is_last   = (chk_idx_r == AW'(SLOTS - 1));

  always_comb begin
    state_nxt   = state_r;
    iss_nxt     = iss_r;
    chk_vld_nxt = 1'b0;
    chk_idx_nxt = chk_idx_r;
    flush_nxt   = flush_r;
    res_nxt     = res_r;
    ram_we      = 1'b0;
    ram_waddr   = chk_idx_r;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = iss_r[AW-1:0];

    case (state_r)
      S_CLEAR: begin
        // sweep zeros through every slot
        ram_we    = 1'b1;
        ram_waddr = iss_r[AW-1:0];
        iss_nxt   = iss_r + CW'(1);
        if (iss_r == CW'(SLOTS - 1)) begin
          iss_nxt = '0;
          if (flush_r) begin
            res_nxt   = '{st: fatt_pkg::ST_OK, phys: '0, flags: '0};
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          iss_nxt   = '0;
          flush_nxt = 1'b0;
          case (in_mode)
            fatt_pkg::OP_MAP,
            fatt_pkg::OP_UNMAP,
            fatt_pkg::OP_LOOKUP,
            fatt_pkg::OP_FLUSH_RANGE: begin
              state_nxt = S_SCAN;
            end
            fatt_pkg::OP_FLUSH_ALL: begin
              flush_nxt = 1'b1;
              state_nxt = S_CLEAR;
            end
            default: begin
              res_nxt   = '{st: fatt_pkg::ST_FAIL, phys: '0, flags: '0};
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue the next slot read while the previous one is checked
        if (iss_r < CW'(SLOTS)) begin
          ram_re      = 1'b1;
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = iss_r[AW-1:0];
          iss_nxt     = iss_r + CW'(1);
        end
        if (chk_vld_r) begin
          res_nxt = '{st: fatt_pkg::ST_FAIL, phys: '0, flags: '0};
          if (is_last) begin
            state_nxt = S_DONE;
            if (mode_r == fatt_pkg::OP_FLUSH_RANGE) begin
              res_nxt.st = fatt_pkg::ST_OK;
            end
          end
          case (mode_r)
            fatt_pkg::OP_MAP: begin
              if (slot_free) begin
                ram_we     = 1'b1;
                ram_wdata  = {va_r, pa_r | {{(DW-FW){1'b0}}, fl_r}};
                res_nxt.st = fatt_pkg::ST_OK;
                state_nxt  = S_DONE;
              end
            end
            fatt_pkg::OP_UNMAP: begin
              if (tag_hit) begin
                ram_we     = 1'b1;
                res_nxt.st = fatt_pkg::ST_OK;
                state_nxt  = S_DONE;
              end
            end
            fatt_pkg::OP_LOOKUP: begin
              if (tag_hit) begin
                res_nxt.st    = fatt_pkg::ST_OK;
                res_nxt.phys  = {slot_word[DW-1:FW], {FW{1'b0}}};
                res_nxt.flags = slot_word[FW-1:0];
                state_nxt     = S_DONE;
              end
            end
            fatt_pkg::OP_FLUSH_RANGE: begin
              ram_we = in_rng;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
          if (state_nxt == S_DONE) begin
            chk_vld_nxt = 1'b0;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      iss_r       <= '0;
      chk_vld_r   <= 1'b0;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      chk_vld_r   <= chk_vld_nxt;
      flush_r     <= flush_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r <= chk_idx_nxt;
    res_r     <= res_nxt;
    if (in_acc) begin
      mode_r <= in_mode;
      va_r   <= in_virt_addr;
      vend_r <= in_range_end;
      pa_r   <= in_phys_addr;
      fl_r   <= in_page_flags;
    end
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_r <= res_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_r.st;
  assign out_found_phys  = out_r.phys;
  assign out_found_flags = out_r.flags;

  // a lookup never modifies the table
  a_lookup_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && mode_r == fatt_pkg::OP_LOOKUP) |-> !ram_we)
    else $error("RAM written during lookup scan");

  // checked data always comes from a read issued the cycle before
  a_chk_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    chk_vld_r |-> $past(ram_re))
    else $error("slot checked without a preceding read");

  // a result only appears out of the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result loaded outside done state");

endmodule
